[rtl/core/plhn_pkg.sv]
// Shared package of the patch level histogram normalizer.
// Holds the command codes, the fixed field widths and the parameter defaults.
`default_nettype none
package plhn_pkg;

    // Parameter defaults
    localparam int PIXELS_DEF     = 64;
    localparam int LEVELS_DEF     = 5;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed word layout
    localparam int PIXEL_W      = 6;
    localparam int LEVEL_W      = 3;
    localparam int AMOUNT_W     = 16;
    localparam int SHARE_W      = 16;
    localparam int SHARE_FIELDS = 5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Command codes, equal to the kind field
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_NORM  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage
`default_nettype wire

[rtl/core/plhn_ram.sv]
// Generic single write port RAM with one registered read port.
// Depends on nothing.
`default_nettype none
module plhn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/core/plhn_front.sv]
// Front part: accepts input words, drops out-of-range updates, queues commands.
// Depends on plhn_pkg.
`default_nettype none
module plhn_front #(
    parameter int PIXELS = plhn_pkg::PIXELS_DEF,
    parameter int LEVELS = plhn_pkg::LEVELS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         kind,
    input  wire logic [plhn_pkg::PIXEL_W-1:0]       pixel,
    input  wire logic [plhn_pkg::LEVEL_W-1:0]       level,
    input  wire logic [plhn_pkg::AMOUNT_W-1:0]      amount,
    output logic                                    q_valid,
    input  wire logic                               q_pop,
    output plhn_pkg::op_t                           q_op,
    output logic [$clog2(PIXELS)-1:0]               q_pix,
    output logic [$clog2(LEVELS)-1:0]               q_lev,
    output logic [plhn_pkg::AMOUNT_W-1:0]           q_amt
);
    import plhn_pkg::*;

    localparam int PIX_W = $clog2(PIXELS);
    localparam int LEV_W = $clog2(LEVELS);
    localparam int QW    = $clog2(QUEUE_DEPTH);

    op_t              op_mem  [QUEUE_DEPTH];
    logic [PIX_W-1:0] pix_mem [QUEUE_DEPTH];
    logic [LEV_W-1:0] lev_mem [QUEUE_DEPTH];
    logic [AMOUNT_W-1:0] amt_mem [QUEUE_DEPTH];

    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   cnt_reg, cnt_next;

    logic full, accept, keep, push;
    op_t  in_op;

    // Classify the word: updates outside the table are dropped
    always_comb
    begin
        in_op = op_t'(kind);
        case (in_op)
            OP_ADD, OP_MERGE: keep = (32'(pixel) < PIXELS) && (32'(level) < LEVELS);
            OP_NORM, OP_CLEAR: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign full     = (cnt_reg == (QW+1)'(QUEUE_DEPTH));
    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign push     = accept && keep;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QW+1)'(push) - (QW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the command; an add hit carries an amount of one
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= in_op;
            pix_mem[wr_ptr_reg] <= PIX_W'(pixel);
            lev_mem[wr_ptr_reg] <= LEV_W'(level);
            amt_mem[wr_ptr_reg] <= (in_op == OP_ADD) ? AMOUNT_W'(1) : amount;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_op    = op_mem[rd_ptr_reg];
    assign q_pix   = pix_mem[rd_ptr_reg];
    assign q_lev   = lev_mem[rd_ptr_reg];
    assign q_amt   = amt_mem[rd_ptr_reg];

endmodule
`default_nettype wire

[rtl/core/plhn_back.sv]
// Back part: counter table updates, clear, and the per-pixel share divider.
// Depends on plhn_pkg and plhn_ram.
`default_nettype none
module plhn_back #(
    parameter int PIXELS     = plhn_pkg::PIXELS_DEF,
    parameter int LEVELS     = plhn_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = plhn_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = plhn_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire plhn_pkg::op_t                 q_op,
    input  wire logic [$clog2(PIXELS)-1:0]     q_pix,
    input  wire logic [$clog2(LEVELS)-1:0]     q_lev,
    input  wire logic [plhn_pkg::AMOUNT_W-1:0] q_amt,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [plhn_pkg::PIXEL_W-1:0]       out_pixel,
    output logic [plhn_pkg::SHARE_W-1:0]       share_zero,
    output logic [plhn_pkg::SHARE_W-1:0]       share_one,
    output logic [plhn_pkg::SHARE_W-1:0]       share_two,
    output logic [plhn_pkg::SHARE_W-1:0]       share_three,
    output logic [plhn_pkg::SHARE_W-1:0]       share_four,
    output logic                               empty_pixel,
    output logic                               last
);
    import plhn_pkg::*;

    localparam int PIX_W  = $clog2(PIXELS);
    localparam int LEV_W  = $clog2(LEVELS);
    localparam int ROW_W  = LEVELS * COUNT_BITS;
    localparam int TOT_W  = COUNT_BITS + $clog2(LEVELS);
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int ADD_W  = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
    localparam int LANES  = (LEVELS > SHARE_FIELDS) ? LEVELS : SHARE_FIELDS;
    localparam logic [ADD_W-1:0] CMAX = ADD_W'({COUNT_BITS{1'b1}});

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_UPD   = 5'b00010,
        ST_NLOAD = 5'b00100,
        ST_NDIV  = 5'b01000,
        ST_NOUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [PIXELS-1:0]     row_valid_reg, row_valid_next;
    logic                  rv_reg;
    logic [PIX_W-1:0]      upd_pix_reg;
    logic [LEV_W-1:0]      upd_lev_reg;
    logic [AMOUNT_W-1:0]   upd_amt_reg;
    logic [PIX_W-1:0]      p_reg, p_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TOT_W-1:0]      tot_reg;
    logic [TOT_W-1:0]      rem_reg [LANES];
    logic [FRAC_BITS-1:0]  quo_reg [LANES];

    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    out_pixel_reg;
    logic [SHARE_W-1:0]    share_reg [SHARE_FIELDS];
    logic                  empty_reg;
    logic                  last_reg;

    logic [PIX_W-1:0]      raddr;
    logic [ROW_W-1:0]      rdata, old_row, wrow;
    logic                  we;
    logic [COUNT_BITS-1:0] old_cnt, new_cnt;
    logic [ADD_W-1:0]      add_sum;
    logic [TOT_W-1:0]      load_cnt [LANES];
    logic [TOT_W-1:0]      load_tot;
    logic [TOT_W-1:0]      div_rem [LANES];
    logic [FRAC_BITS-1:0]  div_quo [LANES];
    logic [TOT_W:0]        dbl;
    logic                  slot_free, out_load, is_last;

    plhn_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PIXELS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (upd_pix_reg),
        .wdata (wrow),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || !out_stall;
    assign is_last   = (p_reg == PIX_W'(PIXELS - 1));
    assign out_load  = (state_reg == ST_NOUT) && slot_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign we        = (state_reg == ST_UPD);

    // Pick the row to read: the queued pixel, row zero, or the next pixel
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            raddr = (q_op == OP_NORM) ? '0 : q_pix;
        end
        else
        begin
            raddr = p_reg + 1'b1;
        end
    end

    // Saturating update of one counter; a row never written reads as zero
    always_comb
    begin
        old_row = rv_reg ? rdata : '0;
        old_cnt = old_row[upd_lev_reg*COUNT_BITS +: COUNT_BITS];
        add_sum = ADD_W'(old_cnt) + ADD_W'(upd_amt_reg);
        new_cnt = (add_sum > CMAX) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(add_sum);
        for (int l = 0; l < LEVELS; l++)
        begin
            wrow[l*COUNT_BITS +: COUNT_BITS] =
                (LEV_W'(l) == upd_lev_reg) ? new_cnt : old_row[l*COUNT_BITS +: COUNT_BITS];
        end
    end

    // Unpack the row read for normalizing and sum the pixel total
    always_comb
    begin
        load_tot = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (l < LEVELS && rv_reg)
            begin
                load_cnt[l] = TOT_W'(rdata[l*COUNT_BITS +: COUNT_BITS]);
            end
            else
            begin
                load_cnt[l] = '0;
            end
            load_tot = load_tot + load_cnt[l];
        end
    end

    // One restoring division step in every lane
    always_comb
    begin
        dbl = '0;
        for (int l = 0; l < LANES; l++)
        begin
            dbl = {rem_reg[l], 1'b0};
            if (dbl >= {1'b0, tot_reg})
            begin
                div_rem[l] = TOT_W'(dbl - {1'b0, tot_reg});
                div_quo[l] = {quo_reg[l][FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                div_rem[l] = TOT_W'(dbl);
                div_quo[l] = {quo_reg[l][FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // Sequence the commands
    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        p_next         = p_reg;
        step_next      = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_op)
                        OP_ADD, OP_MERGE: state_next = ST_UPD;
                        OP_NORM:
                        begin
                            p_next     = '0;
                            state_next = ST_NLOAD;
                        end
                        OP_CLEAR: row_valid_next = '0;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD:
            begin
                row_valid_next[upd_pix_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_NLOAD:
            begin
                step_next  = '0;
                state_next = ST_NDIV;
            end
            ST_NDIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_BITS - 1))
                begin
                    state_next = ST_NOUT;
                end
            end
            ST_NOUT:
            begin
                if (slot_free)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_NLOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            rv_reg        <= row_valid_reg[raddr];
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the working data of the current command
    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        step_reg <= step_next;
        if (q_pop)
        begin
            upd_pix_reg <= q_pix;
            upd_lev_reg <= q_lev;
            upd_amt_reg <= q_amt;
        end
        if (state_reg == ST_NLOAD)
        begin
            tot_reg <= load_tot;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l] <= load_cnt[l];
                quo_reg[l] <= '0;
            end
        end
        else if (state_reg == ST_NDIV)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l] <= div_rem[l];
                quo_reg[l] <= div_quo[l];
            end
        end
    end

    // Load the result word; an empty pixel gives zero shares
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pixel_reg <= PIXEL_W'(p_reg);
            empty_reg     <= (tot_reg == '0);
            last_reg      <= is_last;
            for (int f = 0; f < SHARE_FIELDS; f++)
            begin
                if (tot_reg == '0)
                begin
                    share_reg[f] <= '0;
                end
                else if (32'(quo_reg[f]) > 32'hFFFF)
                begin
                    share_reg[f] <= '1;
                end
                else
                begin
                    share_reg[f] <= SHARE_W'(quo_reg[f]);
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign share_zero  = share_reg[0];
    assign share_one   = share_reg[1];
    assign share_two   = share_reg[2];
    assign share_three = share_reg[3];
    assign share_four  = share_reg[4];
    assign empty_pixel = empty_reg;
    assign last        = last_reg;

    // Final pixel of a pass carries the last flag
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && is_last |=> last_reg && out_valid_reg)
        else $error("last flag missing on final pixel");

    // An empty pixel never shows a nonzero share
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |-> (share_reg[0] == '0) && (share_reg[1] == '0)
            && (share_reg[2] == '0) && (share_reg[3] == '0) && (share_reg[4] == '0))
        else $error("empty pixel with nonzero share");

    // A clear drops every row
    a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (q_op == OP_CLEAR) |=> (row_valid_reg == '0))
        else $error("rows still valid after clear");

endmodule
`default_nettype wire

[rtl/core/patch_level_histogram_normalizer.sv]
// Patch level histogram normalizer, top level.
// Depends on plhn_pkg, plhn_front, plhn_back (which holds plhn_ram).
//
// A counter table holds one saturating count per pixel and intensity level,
// stored as one RAM row of LEVELS counts per pixel, with one valid flip-flop
// per row so that reset and a clear word empty the table at once. Input words
// enter a four-deep command queue at one per cycle while it has room; add and
// merge words outside the table are dropped there. The back end does an add
// or merge as a row read, then a write back; a clear drops every row valid
// flag. A normalize takes each pixel through load, divide and output, which
// waits out any output stall; the bit-serial restoring divider forms all level
// shares of one pixel in parallel lanes, one quotient bit per cycle.
`default_nettype none
module patch_level_histogram_normalizer #(
    parameter int PIXELS     = plhn_pkg::PIXELS_DEF,
    parameter int LEVELS     = plhn_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = plhn_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = plhn_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [plhn_pkg::PIXEL_W-1:0]  pixel,
    input  wire logic [plhn_pkg::LEVEL_W-1:0]  level,
    input  wire logic [plhn_pkg::AMOUNT_W-1:0] amount,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [plhn_pkg::PIXEL_W-1:0]       out_pixel,
    output logic [plhn_pkg::SHARE_W-1:0]       share_zero,
    output logic [plhn_pkg::SHARE_W-1:0]       share_one,
    output logic [plhn_pkg::SHARE_W-1:0]       share_two,
    output logic [plhn_pkg::SHARE_W-1:0]       share_three,
    output logic [plhn_pkg::SHARE_W-1:0]       share_four,
    output logic                               empty_pixel,
    output logic                               last
);
    import plhn_pkg::*;

    localparam int PIX_W = $clog2(PIXELS);
    localparam int LEV_W = $clog2(LEVELS);

    logic                q_valid, q_pop;
    op_t                 q_op;
    logic [PIX_W-1:0]    q_pix;
    logic [LEV_W-1:0]    q_lev;
    logic [AMOUNT_W-1:0] q_amt;

    // Accept and queue
    plhn_front #(
        .PIXELS (PIXELS),
        .LEVELS (LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .pixel    (pixel),
        .level    (level),
        .amount   (amount),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op),
        .q_pix    (q_pix),
        .q_lev    (q_lev),
        .q_amt    (q_amt)
    );

    // Execute
    plhn_back #(
        .PIXELS     (PIXELS),
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_op        (q_op),
        .q_pix       (q_pix),
        .q_lev       (q_lev),
        .q_amt       (q_amt),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_pixel   (out_pixel),
        .share_zero  (share_zero),
        .share_one   (share_one),
        .share_two   (share_two),
        .share_three (share_three),
        .share_four  (share_four),
        .empty_pixel (empty_pixel),
        .last        (last)
    );

endmodule
`default_nettype wire

[verif/tb_patch_level_histogram_normalizer.sv]
// Testbench for the patch level histogram normalizer.
// Depends on plhn_pkg and patch_level_histogram_normalizer; self-checking with a
// scoreboard class that predicts the per-pixel level shares.
`timescale 1ns / 1ps

module tb_patch_level_histogram_normalizer;
    import plhn_pkg::*;

    localparam int NPIX = 64;
    localparam int NLEV = 5;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [5:0]  pix;
        logic [15:0] s0, s1, s2, s3, s4;
        logic        empty;
        logic        lst;
    } share_word_t;

    // Histogram predictor and expected share queue
    class share_scoreboard;
        logic [15:0]  counts [NPIX*NLEV];
        share_word_t  pending [$];
        int           errors;

        function void wipe();
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void bump_count(int p, int l, int add);
            int v;
            if (l >= NLEV) return;
            v = counts[p*NLEV+l] + add;
            if (v > 65535) v = 65535;
            counts[p*NLEV+l] = v[15:0];
        endfunction

        function logic [15:0] frac(longint c, longint tot);
            longint q;
            if (tot == 0) return '0;
            q = (c << 16) / tot;
            if (q > 65535) q = 65535;
            return q[15:0];
        endfunction

        function void note_word(op_t op, int p, int l, int amt);
            share_word_t w;
            longint tot;
            case (op)
                OP_ADD:   bump_count(p, l, 1);
                OP_MERGE: bump_count(p, l, amt);
                OP_CLEAR: wipe();
                default:
                begin
                    for (int i = 0; i < NPIX; i++)
                    begin
                        tot = 0;
                        for (int k = 0; k < NLEV; k++) tot += counts[i*NLEV+k];
                        w.pix   = i[5:0];
                        w.s0    = frac(counts[i*NLEV+0], tot);
                        w.s1    = frac(counts[i*NLEV+1], tot);
                        w.s2    = frac(counts[i*NLEV+2], tot);
                        w.s3    = frac(counts[i*NLEV+3], tot);
                        w.s4    = frac(counts[i*NLEV+4], tot);
                        w.empty = (tot == 0);
                        w.lst   = (i == NPIX-1);
                        pending = {pending, w};
                    end
                end
            endcase
        endfunction

        function void check_word(share_word_t got);
            share_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t mismatch pixel %0d: expected %h actual %h",
                         $realtime, want.pix, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  kind;
    logic [5:0]  pixel, out_pixel;
    logic [2:0]  level;
    logic [15:0] amount;
    logic [15:0] share_zero, share_one, share_two, share_three, share_four;
    logic        empty_pixel, last;

    share_scoreboard sb;
    int  send_idle_pct, recv_stall_pct;
    longint cycles;

    patch_level_histogram_normalizer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .pixel(pixel), .level(level), .amount(amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_pixel(out_pixel), .share_zero(share_zero), .share_one(share_one),
        .share_two(share_two), .share_three(share_three), .share_four(share_four),
        .empty_pixel(empty_pixel), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Count cycles and stop a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[patch_level_histogram_normalizer] ERROR");
                $finish;
            end
        end
    end

    // Sample results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word({out_pixel, share_zero, share_one, share_two, share_three,
                           share_four, empty_pixel, last});
    end

    // Drive receiver stall at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one word, holding it until accepted; valid drops when idling or draining
    task automatic send_word(op_t op, int p, int l, int amt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        pixel    <= p[5:0];
        level    <= l[2:0];
        amount   <= amt[15:0];
        do @(posedge clk); while (in_stall);
        sb.note_word(op, p, l, amt);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Random word: mostly counter updates, with normalizes and rare clears
    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_word(OP_ADD, $urandom_range(63), $urandom_range(7), $urandom);
        else if (r < 88)
            send_word(OP_MERGE, $urandom_range(63), $urandom_range(7),
                      ($urandom_range(3) == 0) ? $urandom_range(65535)
                                               : $urandom_range(300));
        else if (r < 97)
            send_word(OP_NORM, $urandom_range(63), $urandom_range(7), $urandom);
        else
            send_word(OP_CLEAR, $urandom_range(63), $urandom_range(7), $urandom);
    endtask

    initial
    begin
        sb = new();
        sb.wipe();
        sb.errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0; out_stall = 1'b0;
        kind = OP_ADD; pixel = '0; level = '0; amount = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, extremes, saturation, ignored levels, clear
        send_word(OP_NORM, 0, 0, 0);
        send_word(OP_ADD, 0, 0, 0);
        send_word(OP_ADD, 63, 4, 65535);
        send_word(OP_MERGE, 63, 4, 65535);
        send_word(OP_MERGE, 63, 4, 65535);
        send_word(OP_MERGE, 63, 0, 65535);
        send_word(OP_MERGE, 5, 7, 1000);
        send_word(OP_ADD, 5, 5, 0);
        send_word(OP_MERGE, 7, 1, 1);
        send_word(OP_MERGE, 7, 2, 2);
        send_word(OP_MERGE, 7, 3, 0);
        send_word(OP_ADD, 9, 2, 0);
        send_word(OP_MERGE, 42, 3, 21845);
        send_word(OP_MERGE, 42, 1, 43690);
        send_word(OP_NORM, 63, 7, 65535);
        drain_results();
        send_word(OP_CLEAR, 0, 0, 0);
        send_word(OP_NORM, 21, 5, 43690);
        drain_results();

        // Random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 52) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 52) : 0;
            for (int n = 0; n < 80; n++) random_word();
            send_word(OP_NORM, 0, 0, 0);
            // pause the sender until everything has come out
            drain_results();
        end

        drain_results();
        if (sb.errors == 0)
            $display("[patch_level_histogram_normalizer] OK");
        else
            $display("[patch_level_histogram_normalizer] ERROR");
        $finish;
    end

    // Leftover expectations are caught by drain before the verdict
endmodule

[files.f]
rtl/core/plhn_pkg.sv
rtl/core/plhn_ram.sv
rtl/core/plhn_front.sv
rtl/core/plhn_back.sv
rtl/core/patch_level_histogram_normalizer.sv
verif/tb_patch_level_histogram_normalizer.sv
